@@ hw/rtl/ipv4rs_pkg.sv @@
// Shared types and constants for the IPv4 route select block.
`timescale 1ns / 1ps
`default_nettype none
package ipv4rs_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic        command;
        logic [3:0]  entry_index;
        logic        entry_valid;
        logic        entry_is_default;
        logic [31:0] entry_dest;
        logic [31:0] entry_mask;
        logic [31:0] entry_priority;
        logic [31:0] lookup_addr;
        logic        lookup_is_ipv6;
    } t_in;

    typedef struct packed {
        logic        found;
        logic [3:0]  route_index;
        logic        used_default;
        logic [31:0] route_metric;
    } t_out;

    // One table slot as read out for comparison.
    typedef struct packed {
        logic        valid;
        logic        dflt;
        logic [31:0] dest;
        logic [31:0] mask;
        logic [31:0] prio;
        t_idx        idx;
    } t_entry;

    // Sequencer controls to the selection unit.
    typedef struct packed {
        logic clr;
        logic en;
    } t_sel_ctl;

endpackage
`default_nettype wire

@@ hw/rtl/ipv4_route_select_top.sv @@
// Top level of the IPv4 route select block: command sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
// IPv4 route table with best-route selection. A transaction is taken at a
// rising edge with start high and busy low. A write command fills one slot
// (a slot index beyond the table is ignored) and returns an all-zero result
// in the next cycle without raising busy; an IPv6 lookup does the same. An
// IPv4 lookup raises busy and walks the table one slot a cycle through a
// single match and priority comparator, paced by the one registered read
// port of the table; the last slot read then passes the comparator, and
// the result register takes the best route. The lowest-priority matching
// non-default slot wins, ties to the lower index; failing that the
// lowest-priority default slot. Each result is flagged by o_strobe high
// for exactly one cycle and stays on o_result until the
// next result; the receiver cannot stall it, so it must take it
// then. No clearing pass is needed after reset: slot flags reset at once.
module ipv4_route_select_top (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire ipv4rs_pkg::t_in  i_item,
    output logic                  o_strobe,
    output ipv4rs_pkg::t_out      o_result
);
    import ipv4rs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    t_idx        r_cnt, n_cnt;
    logic [31:0] r_addr;
    logic        r_rd_vld;
    logic        r_strobe, n_strobe;
    t_out        r_out, n_out;

    logic        accept;
    logic        wr_en;
    t_sel_ctl    sel_ctl;
    t_entry      rd_entry;
    t_out        sel_res;

    assign accept = start && (r_state == ST_IDLE);
    // out-of-range slot writes are dropped
    assign wr_en  = accept && (i_item.command == CMD_WRITE)
                    && (32'(i_item.entry_index) < 32'(TABLE_DEPTH));

    ipv4rs_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_addr  (IDX_W'(i_item.entry_index)),
        .i_wr_item  (i_item),
        .i_rd_addr  (r_cnt),
        .o_rd_entry (rd_entry)
    );

    always_comb begin
        sel_ctl.clr = accept;
        sel_ctl.en  = r_rd_vld;
    end

    ipv4rs_sel u_sel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sel_ctl),
        .i_addr  (r_addr),
        .i_entry (rd_entry),
        .o_res   (sel_res)
    );

    // sequencer: IDLE takes a transaction, SCAN issues reads, DRAIN lets the
    // last read through the comparator, DONE registers the result
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_strobe = 1'b0;
        n_out    = r_out;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_item.command == CMD_WRITE || i_item.lookup_is_ipv6) begin
                        n_strobe = 1'b1;
                        n_out    = '0;
                    end else begin
                        n_cnt   = '0;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == IDX_W'(TABLE_DEPTH - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                n_strobe = 1'b1;
                n_out    = sel_res;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_rd_vld <= (r_state == ST_SCAN);
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (accept) begin
            r_addr <= i_item.lookup_addr;
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // an IPv4 lookup always starts a scan
    a_lookup_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.command == CMD_LOOKUP && !i_item.lookup_is_ipv6)
        |=> (r_state == ST_SCAN))
        else $error("lookup did not start a scan");

    a_done_strobes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> o_strobe)
        else $error("scan finished without a result");

    // only a finished scan can report a route
    a_found_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.found) |-> $past(r_state == ST_DONE))
        else $error("route reported outside a scan");

    a_default_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.used_default) |-> o_result.found)
        else $error("default flag without a route");

    a_read_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> $past(r_state == ST_SCAN))
        else $error("compare enabled outside a scan");

endmodule
`default_nettype wire

@@ hw/rtl/ipv4rs_table.sv @@
// Route table storage: flag flops plus destination, mask and priority memories.
`timescale 1ns / 1ps
`default_nettype none
module ipv4rs_table (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr_en,
    input  wire ipv4rs_pkg::t_idx  i_wr_addr,
    input  wire ipv4rs_pkg::t_in   i_wr_item,
    input  wire ipv4rs_pkg::t_idx  i_rd_addr,
    output ipv4rs_pkg::t_entry     o_rd_entry
);
    import ipv4rs_pkg::*;

    logic [31:0] mem_dest [TABLE_DEPTH];
    logic [31:0] mem_mask [TABLE_DEPTH];
    logic [31:0] mem_prio [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [TABLE_DEPTH-1:0] r_dflt;
    t_entry r_rd;

    // flags are reset; payload memories are left undefined until written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dflt  <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= i_wr_item.entry_valid;
            r_dflt[i_wr_addr]  <= i_wr_item.entry_is_default;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_dest[i_wr_addr] <= i_wr_item.entry_dest;
            mem_mask[i_wr_addr] <= i_wr_item.entry_mask;
            mem_prio[i_wr_addr] <= i_wr_item.entry_priority;
        end
        r_rd.valid <= r_valid[i_rd_addr];
        r_rd.dflt  <= r_dflt[i_rd_addr];
        r_rd.dest  <= mem_dest[i_rd_addr];
        r_rd.mask  <= mem_mask[i_rd_addr];
        r_rd.prio  <= mem_prio[i_rd_addr];
        r_rd.idx   <= i_rd_addr;
    end

    assign o_rd_entry = r_rd;

endmodule
`default_nettype wire

@@ hw/rtl/ipv4rs_sel.sv @@
// Shared match and priority compare unit holding the running best routes.
`timescale 1ns / 1ps
`default_nettype none
module ipv4rs_sel (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ipv4rs_pkg::t_sel_ctl i_ctl,
    input  wire logic [31:0]         i_addr,
    input  wire ipv4rs_pkg::t_entry  i_entry,
    output ipv4rs_pkg::t_out         o_res
);
    import ipv4rs_pkg::*;

    logic        r_hit;
    t_idx        r_hit_idx;
    logic [31:0] r_hit_prio;
    logic        r_dflt;
    t_idx        r_dflt_idx;
    logic [31:0] r_dflt_prio;

    logic        cand_have;
    logic [31:0] cand_prio;
    logic        better;
    logic        addr_match;
    logic        take;

    // one comparator, pointed at the default or the non-default best
    always_comb begin
        cand_have  = i_entry.dflt ? r_dflt : r_hit;
        cand_prio  = i_entry.dflt ? r_dflt_prio : r_hit_prio;
        better     = !cand_have || (i_entry.prio < cand_prio);
        addr_match = ((i_entry.dest ^ i_addr) & i_entry.mask) == 32'd0;
        take       = i_ctl.en && i_entry.valid && better && (i_entry.dflt || addr_match);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_hit  <= 1'b0;
            r_dflt <= 1'b0;
        end else if (take) begin
            if (i_entry.dflt) begin
                r_dflt <= 1'b1;
            end else begin
                r_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_entry.dflt) begin
            r_dflt_idx  <= i_entry.idx;
            r_dflt_prio <= i_entry.prio;
        end
        if (take && !i_entry.dflt) begin
            r_hit_idx  <= i_entry.idx;
            r_hit_prio <= i_entry.prio;
        end
    end

    always_comb begin
        o_res = '0;
        if (r_hit) begin
            o_res.found        = 1'b1;
            o_res.route_index  = 4'(r_hit_idx);
            o_res.route_metric = r_hit_prio;
        end else if (r_dflt) begin
            o_res.found        = 1'b1;
            o_res.used_default = 1'b1;
            o_res.route_index  = 4'(r_dflt_idx);
            o_res.route_metric = r_dflt_prio;
        end
    end

endmodule
`default_nettype wire
